[sv/afhp_pkg.sv]
package afhp_pkg;

   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned CSR_IDX_W  = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_BIT_PERIOD   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MARK_HALF    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPACE_HALF   = 2'd2;

   localparam logic [31:0] BIT_PERIOD_RST = 32'd54613333;
   localparam logic [31:0] MARK_HALF_RST  = 32'd27306667;
   localparam logic [31:0] SPACE_HALF_RST = 32'd14894545;

   typedef struct packed {
      logic [15:0] half_us;
      logic        zero;
   } rnd_res_type;

   typedef struct packed {
      logic [31:0] bit_period;
      logic [31:0] mark_half;
      logic [31:0] space_half;
   } cfg_type;

endpackage

[sv/afhp_rounder.sv]
module afhp_rounder import afhp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        round_en,
   input  logic [31:0] piece,
   output rnd_res_type res
);

   logic signed [16:0] carry_ff;
   logic signed [16:0] carry_in;
   logic signed [33:0] v;
   logic signed [17:0] fl;
   logic        [15:0] frac;
   logic               inc;
   logic        [17:0] q;

   always_comb begin
      v    = $signed({2'b00, piece}) + 34'(carry_ff);
      fl   = v[33:16];
      frac = v[15:0];
      inc  = (frac > 16'h8000) || ((frac == 16'h8000) && fl[0]);
      q    = 18'(fl) + 18'(inc);
      carry_in = inc ? $signed({1'b1, frac}) : $signed({1'b0, frac});
      res.zero    = (q == 18'd0);
      res.half_us = (q[17:16] != 2'b00) ? 16'hFFFF : q[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         carry_ff <= '0;
      end else if (round_en) begin
         carry_ff <= carry_in;
      end
   end

endmodule

[sv/afhp_seq.sv]
module afhp_seq import afhp_pkg::*; #(
   parameter int unsigned MAX_HALVES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_line_bit,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_half_us,
   output logic        rsp_last,
   output logic        round_en,
   output logic [31:0] piece,
   input  rnd_res_type res
);

   localparam int unsigned TW = $clog2(MAX_HALVES);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_CHECK = 2'd1;
   localparam logic [1:0] S_ROUND = 2'd2;
   localparam logic [1:0] S_OUT   = 2'd3;

   logic [1:0]    state_ff, state_in;
   logic          tone_ff, tone_in;
   logic [31:0]   done_ff, done_in;
   logic [TW-1:0] taken_ff, taken_in;
   logic [31:0]   piece_ff, piece_in;
   logic          final_ff, final_in;
   logic [15:0]   half_us_ff, half_us_in;
   logic          last_ff, last_in;
   logic [31:0]   half;
   logic [32:0]   sum;
   logic          more;

   assign half = tone_ff ? cfg.mark_half : cfg.space_half;
   assign sum  = {1'b0, done_ff} + {1'b0, half};
   assign more = (taken_ff < TW'(MAX_HALVES - 1)) && (sum < {1'b0, cfg.bit_period});

   assign req_ready   = (state_ff == S_IDLE);
   assign rsp_valid   = (state_ff == S_OUT);
   assign rsp_half_us = half_us_ff;
   assign rsp_last    = last_ff;
   assign round_en    = (state_ff == S_ROUND);
   assign piece       = piece_ff;

   always_comb begin
      state_in   = state_ff;
      tone_in    = tone_ff;
      done_in    = done_ff;
      taken_in   = taken_ff;
      piece_in   = piece_ff;
      final_in   = final_ff;
      half_us_in = half_us_ff;
      last_in    = last_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (!req_line_bit) begin
                  tone_in = !tone_ff;
               end
               done_in  = '0;
               taken_in = '0;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            piece_in = more ? half : (cfg.bit_period - done_ff);
            final_in = !more;
            state_in = S_ROUND;
         end
         S_ROUND: begin
            if (!final_ff) begin
               done_in  = sum[31:0];
               taken_in = taken_ff + TW'(1);
            end
            if (final_ff || !res.zero) begin
               half_us_in = res.half_us;
               last_in    = final_ff;
               state_in   = S_OUT;
            end else begin
               state_in = S_CHECK;
            end
         end
         S_OUT: begin
            if (rsp_ready) begin
               state_in = last_ff ? S_IDLE : S_CHECK;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         tone_ff  <= 1'b1;
      end else begin
         state_ff <= state_in;
         tone_ff  <= tone_in;
      end
   end

   always_ff @(posedge clock) begin
      done_ff    <= done_in;
      taken_ff   <= taken_in;
      piece_ff   <= piece_in;
      final_ff   <= final_in;
      half_us_ff <= half_us_in;
      last_ff    <= last_in;
   end

endmodule

[sv/afsk_half_period_generator_unit.sv]
// An accepted request leaves idle for the split/round loop (check, round),
// which runs once per taken half cycle; each result emitted is then held in
// the output register until rsp_ready takes it.
// One request is in flight at a time.
// Reset (synchronous): tone is mark, rounding carry is zero, registers take
// their default periods.
module afsk_half_period_generator_unit import afhp_pkg::*; #(
   parameter int unsigned MAX_HALVES = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_line_bit,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [15:0]           rsp_half_us,
   output logic                  rsp_last,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   cfg_type     cfg_ff;
   logic        round_en;
   logic [31:0] piece;
   rnd_res_type res;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bit_period <= BIT_PERIOD_RST;
         cfg_ff.mark_half  <= MARK_HALF_RST;
         cfg_ff.space_half <= SPACE_HALF_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_BIT_PERIOD: cfg_ff.bit_period <= csr_wr_data;
            CSR_MARK_HALF:  cfg_ff.mark_half  <= csr_wr_data;
            CSR_SPACE_HALF: cfg_ff.space_half <= csr_wr_data;
            default: begin
            end
         endcase
      end
   end

   afhp_seq #(
      .MAX_HALVES (MAX_HALVES)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_line_bit (req_line_bit),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_half_us  (rsp_half_us),
      .rsp_last     (rsp_last),
      .round_en     (round_en),
      .piece        (piece),
      .res          (res)
   );

   afhp_rounder u_rounder (
      .clock    (clock),
      .reset    (reset),
      .round_en (round_en),
      .piece    (piece),
      .res      (res)
   );

endmodule
